/* hdl/ses_pkg.sv */
// ---------------------------------------------------------------------------
// ses_pkg: shared types and constants for the stick expo shaper
// Operation codes, configuration indexes, micro-op command and status
// structs, and fixed-point constants used by the controller and datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package ses_pkg;

    // Input operation codes
    typedef enum logic [2:0] {
        OP_ROLL   = 3'd0,
        OP_PITCH  = 3'd1,
        OP_YAW    = 3'd2,
        OP_THRUST = 3'd3,
        OP_CLEAR  = 3'd4,
        OP_LINK   = 3'd5
    } op_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_EXPO_ROLL   = 3'd0,
        CFG_EXPO_PITCH  = 3'd1,
        CFG_EXPO_YAW    = 3'd2,
        CFG_EXPO_THRUST = 3'd3,
        CFG_ALT_HOLD    = 3'd4
    } cfg_idx_t;

    // Datapath micro-ops
    typedef enum logic [4:0] {
        UOP_IDLE,
        UOP_LOAD,
        UOP_DIRECT,
        UOP_MUL_AE,
        UOP_X_SET,
        UOP_MUL_XL,
        UOP_MUL_FL,
        UOP_EXP_INIT,
        UOP_MUL_TY,
        UOP_MUL_PR,
        UOP_Q_LOAD,
        UOP_TERM,
        UOP_EXP_DONE,
        UOP_MUL_TB,
        UOP_LOG_INIT,
        UOP_LOG_NORM,
        UOP_MUL_MM,
        UOP_LOG_STEP,
        UOP_LOG_DONE,
        UOP_DIV_INIT,
        UOP_DIV_SAT,
        UOP_DIV_STEP,
        UOP_WRITE,
        UOP_CAPTURE
    } uop_t;

    // Command from controller to datapath
    typedef struct packed {
        uop_t uop;
        logic second;   // second operand pass (denominator / base log)
        logic log_path; // division takes log results instead of exp results
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic curve_go;
        logic thrust_go;
        logic m_norm;
        logic k_last;
        logic cnt_last;
        logic div_last;
    } status_t;

    localparam logic [14:0] EXPO_MIN        = 15'd41;
    localparam logic [14:0] THRUST_BASE_MIN = 15'd4137;
    localparam logic [15:0] DEAD_LIMIT      = 16'd1639;
    localparam logic [30:0] LOG2E_Q30       = 31'd1549082005;
    localparam logic [29:0] LN2_Q30         = 30'd744261118;
    localparam logic [30:0] ONE_Q30         = 31'h4000_0000;
    localparam logic [3:0]  TERMS_LAST      = 4'd12;
    localparam logic [4:0]  LOG_BITS_LAST   = 5'd29;
    localparam logic [3:0]  DIV_TOP_BIT     = 4'd14;
    localparam logic [14:0] SAT_MAX         = 15'h7FFF;

    // ceil(2^32 / k): floor(p/k) is this product shifted down, less one at most
    function automatic logic [32:0] recip(input logic [3:0] k);
        logic [32:0] r;
        case (k)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'h0_8000_0000;
            4'd3:    r = 33'h0_5555_5556;
            4'd4:    r = 33'h0_4000_0000;
            4'd5:    r = 33'h0_3333_3334;
            4'd6:    r = 33'h0_2AAA_AAAB;
            4'd7:    r = 33'h0_2492_4925;
            4'd8:    r = 33'h0_2000_0000;
            4'd9:    r = 33'h0_1C71_C71D;
            4'd10:   r = 33'h0_1999_999A;
            4'd11:   r = 33'h0_1745_D175;
            4'd12:   r = 33'h0_1555_5556;
            default: r = 33'h1_0000_0000;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/ses_if.sv */
// ---------------------------------------------------------------------------
// ses_if: request channels of the stick expo shaper
// ses_cmd_if carries stick commands in, ses_sp_if carries setpoints out.
// ---------------------------------------------------------------------------
`default_nettype none

interface ses_cmd_if;
    logic               valid;
    logic               ready;
    logic [2:0]         operation;
    logic signed [15:0] stick_value;

    modport source (output valid, output operation, output stick_value, input ready);
    modport sink   (input valid, input operation, input stick_value, output ready);
endinterface

interface ses_sp_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] roll_setpoint;
    logic signed [15:0] pitch_setpoint;
    logic signed [15:0] yaw_setpoint;
    logic [14:0]        thrust_setpoint;

    modport source (output valid, output roll_setpoint, output pitch_setpoint,
                    output yaw_setpoint, output thrust_setpoint, input ready);
    modport sink   (input valid, input roll_setpoint, input pitch_setpoint,
                    input yaw_setpoint, input thrust_setpoint, output ready);
endinterface

`default_nettype wire

/* hdl/ses_datapath.sv */
// ---------------------------------------------------------------------------
// ses_datapath: arithmetic and storage of the stick expo shaper
// Config registers, setpoint holds, one shared 33x33 multiplier, the exp
// series, the log2 squaring loop and a restoring divider, run by micro-ops.
// ---------------------------------------------------------------------------
`default_nettype none

module ses_datapath (
    input  wire                  clk,
    input  wire                  rst_n,
    input  ses_pkg::cmd_t        cmd,
    output ses_pkg::status_t     status,
    input  wire  [2:0]           operation,
    input  wire  signed [15:0]   stick_value,
    input  wire                  cfg_we,
    input  wire  [2:0]           cfg_index,
    input  wire  [14:0]          cfg_data,
    output logic signed [15:0]   roll_setpoint,
    output logic signed [15:0]   pitch_setpoint,
    output logic signed [15:0]   yaw_setpoint,
    output logic [14:0]          thrust_setpoint
);
    import ses_pkg::*;

    // configuration and holds
    logic [14:0]        expo_roll_reg, expo_pitch_reg, expo_yaw_reg, expo_thrust_reg;
    logic               alt_hold_reg;
    logic signed [15:0] roll_hold_reg, pitch_hold_reg, yaw_hold_reg;
    logic [14:0]        thrust_hold_reg;

    // item and working registers
    logic [2:0]         op_reg;
    logic signed [15:0] v_reg;
    logic [29:0]        x_reg;
    logic [65:0]        prod_reg;
    logic [3:0]         n_reg;
    logic [29:0]        y_reg;
    logic [31:0]        sum_reg;
    logic [30:0]        term_reg;
    logic [3:0]         k_reg;
    logic [29:0]        p_reg;
    logic [30:0]        q_reg;
    logic [43:0]        num_reg, den_reg;
    logic [33:0]        m_reg;
    logic [1:0]         ip_reg;
    logic [29:0]        fr_reg;
    logic [4:0]         cnt_reg;
    logic [31:0]        lw_reg, le_reg;
    logic [59:0]        rem_reg;
    logic [43:0]        dsr_reg;
    logic [14:0]        dq_reg;
    logic [3:0]         div_i_reg;
    logic               sat_reg;

    // operand shaping
    logic signed [16:0] v_ext, val;
    logic [16:0]        abs_v, abs_val;
    logic               neg, dead, t_pos;
    logic [15:0]        a_mag;
    logic [14:0]        e_use, e_thr;
    logic [14:0]        t_val;

    always_comb
    begin
        v_ext   = {v_reg[15], v_reg};
        val     = (op_reg == OP_PITCH) ? -v_ext : v_ext;
        neg     = val[16];
        abs_val = neg ? 17'(-val) : 17'(val);
        abs_v   = v_ext[16] ? 17'(-v_ext) : 17'(v_ext);
        a_mag   = abs_val[15:0];
        dead    = abs_v < {1'b0, DEAD_LIMIT};
        t_pos   = !dead && !v_reg[15];
        t_val   = t_pos ? v_reg[14:0] : 15'd0;
        e_thr   = (expo_thrust_reg < THRUST_BASE_MIN) ? THRUST_BASE_MIN : expo_thrust_reg;
        case (op_reg)
            OP_ROLL:  e_use = (expo_roll_reg < EXPO_MIN) ? EXPO_MIN : expo_roll_reg;
            OP_PITCH: e_use = (expo_pitch_reg < EXPO_MIN) ? EXPO_MIN : expo_pitch_reg;
            OP_YAW:   e_use = (expo_yaw_reg < EXPO_MIN) ? EXPO_MIN : expo_yaw_reg;
            default:  e_use = e_thr;
        endcase
    end

    // status toward the controller
    always_comb
    begin
        status.curve_go  = (op_reg == OP_ROLL) || (op_reg == OP_PITCH) ||
                           ((op_reg == OP_YAW) && !dead);
        status.thrust_go = (op_reg == OP_THRUST) && t_pos && !alt_hold_reg;
        status.m_norm    = (m_reg[33:31] == 3'd0);
        status.k_last    = (k_reg == TERMS_LAST);
        status.cnt_last  = (cnt_reg == LOG_BITS_LAST);
        status.div_last  = (div_i_reg == 4'd0);
    end

    // shared multiplier operand select
    logic [32:0] mul_a, mul_b;
    logic [65:0] mul_p;

    always_comb
    begin
        case (cmd.uop)
            UOP_MUL_AE:
            begin
                mul_a = 33'(a_mag);
                mul_b = 33'(e_use);
            end
            UOP_MUL_XL:
            begin
                mul_a = 33'(x_reg);
                mul_b = 33'(LOG2E_Q30);
            end
            UOP_MUL_FL:
            begin
                mul_a = 33'(prod_reg[56:27]);
                mul_b = 33'(LN2_Q30);
            end
            UOP_MUL_TY:
            begin
                mul_a = 33'(term_reg);
                mul_b = 33'(y_reg);
            end
            UOP_MUL_PR:
            begin
                mul_a = 33'(prod_reg[59:30]);
                mul_b = recip(k_reg);
            end
            UOP_MUL_MM:
            begin
                mul_a = 33'(m_reg[30:0]);
                mul_b = 33'(m_reg[30:0]);
            end
            UOP_MUL_TB:
            begin
                mul_a = 33'(t_val);
                mul_b = 33'(e_thr - 15'd4096);
            end
            default:
            begin
                mul_a = 33'd0;
                mul_b = 33'd0;
            end
        endcase
        mul_p = 66'(mul_a) * 66'(mul_b);
    end

    // series term correction, exp result, squaring, divider compare
    logic [34:0] qk;
    logic [30:0] corr;
    logic [43:0] exp_res;
    logic [31:0] sq;
    logic [59:0] div_cmp;
    logic [14:0] q_fin;

    always_comb
    begin
        qk      = 35'(q_reg) * 35'(k_reg);
        corr    = (qk > 35'(p_reg)) ? (q_reg - 31'd1) : q_reg;
        exp_res = 44'({12'd0, sum_reg} << n_reg);
        sq      = prod_reg[61:30];
        div_cmp = 60'({16'd0, dsr_reg} << div_i_reg);
        q_fin   = sat_reg ? SAT_MAX : dq_reg;
    end

    // configuration, holds and loop counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expo_roll_reg   <= EXPO_MIN;
            expo_pitch_reg  <= EXPO_MIN;
            expo_yaw_reg    <= EXPO_MIN;
            expo_thrust_reg <= THRUST_BASE_MIN;
            alt_hold_reg    <= 1'b0;
            roll_hold_reg   <= '0;
            pitch_hold_reg  <= '0;
            yaw_hold_reg    <= '0;
            thrust_hold_reg <= '0;
            k_reg           <= '0;
            cnt_reg         <= '0;
            div_i_reg       <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_EXPO_ROLL:   expo_roll_reg   <= cfg_data;
                    CFG_EXPO_PITCH:  expo_pitch_reg  <= cfg_data;
                    CFG_EXPO_YAW:    expo_yaw_reg    <= cfg_data;
                    CFG_EXPO_THRUST: expo_thrust_reg <= cfg_data;
                    CFG_ALT_HOLD:    alt_hold_reg    <= cfg_data[0];
                    default:         ;
                endcase
            end
            case (cmd.uop)
                UOP_DIRECT:
                begin
                    case (op_reg)
                        OP_YAW:    yaw_hold_reg    <= '0;
                        OP_THRUST: thrust_hold_reg <= t_val;
                        OP_CLEAR:
                        begin
                            roll_hold_reg   <= '0;
                            pitch_hold_reg  <= '0;
                            yaw_hold_reg    <= '0;
                            thrust_hold_reg <= '0;
                        end
                        OP_LINK:
                        begin
                            roll_hold_reg  <= '0;
                            pitch_hold_reg <= '0;
                        end
                        default: ;
                    endcase
                end
                UOP_EXP_INIT: k_reg <= 4'd1;
                UOP_TERM:     k_reg <= k_reg + 4'd1;
                UOP_LOG_INIT: cnt_reg <= '0;
                UOP_LOG_STEP: cnt_reg <= cnt_reg + 5'd1;
                UOP_LOG_DONE: cnt_reg <= '0;
                UOP_DIV_INIT: div_i_reg <= DIV_TOP_BIT;
                UOP_DIV_STEP: div_i_reg <= div_i_reg - 4'd1;
                UOP_WRITE:
                begin
                    case (op_reg)
                        OP_ROLL:
                            roll_hold_reg <= neg ? 16'(-$signed({1'b0, q_fin}))
                                                 : $signed({1'b0, q_fin});
                        OP_PITCH:
                            pitch_hold_reg <= neg ? 16'(-$signed({1'b0, q_fin}))
                                                  : $signed({1'b0, q_fin});
                        OP_YAW:
                            yaw_hold_reg <= neg ? 16'(-$signed({1'b0, q_fin}))
                                                : $signed({1'b0, q_fin});
                        OP_THRUST: thrust_hold_reg <= q_fin;
                        default: ;
                    endcase
                end
                default: ;
            endcase
        end
    end

    // working payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.uop)
            UOP_LOAD:
            begin
                op_reg <= operation;
                v_reg  <= stick_value;
            end
            UOP_MUL_AE, UOP_MUL_XL, UOP_MUL_TY, UOP_MUL_MM, UOP_MUL_TB:
                prod_reg <= mul_p;
            UOP_MUL_FL:
            begin
                n_reg    <= prod_reg[60:57];
                prod_reg <= mul_p;
            end
            UOP_MUL_PR:
            begin
                p_reg    <= prod_reg[59:30];
                prod_reg <= mul_p;
            end
            UOP_X_SET: x_reg <= prod_reg[29:0];
            UOP_EXP_INIT:
            begin
                y_reg    <= prod_reg[59:30];
                sum_reg  <= 32'(ONE_Q30);
                term_reg <= ONE_Q30;
            end
            UOP_Q_LOAD: q_reg <= prod_reg[62:32];
            UOP_TERM:
            begin
                term_reg <= corr;
                sum_reg  <= sum_reg + 32'(corr);
            end
            UOP_EXP_DONE:
            begin
                if (cmd.second)
                    den_reg <= exp_res - 44'(ONE_Q30);
                else
                begin
                    num_reg <= exp_res - 44'(ONE_Q30);
                    x_reg   <= {e_use, 15'd0};
                end
            end
            UOP_LOG_INIT:
            begin
                m_reg  <= {(31'(prod_reg[29:0]) + 31'h0800_0000), 3'd0};
                ip_reg <= '0;
                fr_reg <= '0;
            end
            UOP_LOG_NORM:
            begin
                if (m_reg[33:31] != 3'd0)
                begin
                    m_reg  <= m_reg >> 1;
                    ip_reg <= ip_reg + 2'd1;
                end
            end
            UOP_LOG_STEP:
            begin
                fr_reg <= {fr_reg[28:0], sq[31]};
                m_reg  <= sq[31] ? 34'(sq >> 1) : 34'(sq);
            end
            UOP_LOG_DONE:
            begin
                if (cmd.second)
                    le_reg <= {ip_reg, fr_reg};
                else
                begin
                    lw_reg <= {ip_reg, fr_reg};
                    m_reg  <= {1'b0, e_thr, 18'd0};
                    ip_reg <= '0;
                    fr_reg <= '0;
                end
            end
            UOP_DIV_INIT:
            begin
                if (cmd.log_path)
                begin
                    rem_reg <= {13'd0, lw_reg, 15'd0} + 60'(le_reg >> 1);
                    dsr_reg <= 44'(le_reg);
                end
                else
                begin
                    rem_reg <= {1'b0, num_reg, 15'd0} + 60'(den_reg >> 1);
                    dsr_reg <= den_reg;
                end
                dq_reg <= '0;
            end
            UOP_DIV_SAT: sat_reg <= rem_reg >= {1'b0, dsr_reg, 15'd0};
            UOP_DIV_STEP:
            begin
                if (rem_reg >= div_cmp)
                begin
                    rem_reg           <= rem_reg - div_cmp;
                    dq_reg[div_i_reg] <= 1'b1;
                end
            end
            UOP_CAPTURE:
            begin
                roll_setpoint   <= roll_hold_reg;
                pitch_setpoint  <= pitch_hold_reg;
                yaw_setpoint    <= yaw_hold_reg;
                thrust_setpoint <= thrust_hold_reg;
            end
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* hdl/ses_ctrl.sv */
// ---------------------------------------------------------------------------
// ses_ctrl: sequencer of the stick expo shaper
// Steps the datapath through the exp curve, the log curve and the divide,
// and owns the input ready and the output valid.
// ---------------------------------------------------------------------------
`default_nettype none

module ses_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire                  out_ready,
    input  ses_pkg::status_t     status,
    output ses_pkg::cmd_t        cmd
);
    import ses_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_X_MUL, S_X_SET,
        S_E_XL, S_E_FL, S_E_INIT, S_E_TY, S_E_PR, S_E_Q, S_E_TERM, S_E_DONE,
        S_W_MUL, S_W_SET, S_L_NORM, S_L_SQ, S_L_STEP, S_L_DONE,
        S_DIV_INIT, S_DIV_SAT, S_DIV_STEP, S_WRITE, S_OUT
    } state_t;

    state_t state_reg;
    logic   second_reg;
    logic   log_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // micro-op for the current step
    always_comb
    begin
        cmd.second   = second_reg;
        cmd.log_path = log_reg;
        case (state_reg)
            S_IDLE:     cmd.uop = in_valid ? UOP_LOAD : UOP_IDLE;
            S_DISPATCH: cmd.uop = (status.curve_go || status.thrust_go) ? UOP_IDLE
                                                                         : UOP_DIRECT;
            S_X_MUL:    cmd.uop = UOP_MUL_AE;
            S_X_SET:    cmd.uop = UOP_X_SET;
            S_E_XL:     cmd.uop = UOP_MUL_XL;
            S_E_FL:     cmd.uop = UOP_MUL_FL;
            S_E_INIT:   cmd.uop = UOP_EXP_INIT;
            S_E_TY:     cmd.uop = UOP_MUL_TY;
            S_E_PR:     cmd.uop = UOP_MUL_PR;
            S_E_Q:      cmd.uop = UOP_Q_LOAD;
            S_E_TERM:   cmd.uop = UOP_TERM;
            S_E_DONE:   cmd.uop = UOP_EXP_DONE;
            S_W_MUL:    cmd.uop = UOP_MUL_TB;
            S_W_SET:    cmd.uop = UOP_LOG_INIT;
            S_L_NORM:   cmd.uop = UOP_LOG_NORM;
            S_L_SQ:     cmd.uop = UOP_MUL_MM;
            S_L_STEP:   cmd.uop = UOP_LOG_STEP;
            S_L_DONE:   cmd.uop = UOP_LOG_DONE;
            S_DIV_INIT: cmd.uop = UOP_DIV_INIT;
            S_DIV_SAT:  cmd.uop = UOP_DIV_SAT;
            S_DIV_STEP: cmd.uop = UOP_DIV_STEP;
            S_WRITE:    cmd.uop = UOP_WRITE;
            S_OUT:      cmd.uop = out_free ? UOP_CAPTURE : UOP_IDLE;
            default:    cmd.uop = UOP_IDLE;
        endcase
    end

    // state, pass flags and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            second_reg    <= 1'b0;
            log_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid)
                        state_reg <= S_DISPATCH;
                S_DISPATCH:
                begin
                    second_reg <= 1'b0;
                    if (status.curve_go)
                    begin
                        log_reg   <= 1'b0;
                        state_reg <= S_X_MUL;
                    end
                    else if (status.thrust_go)
                    begin
                        log_reg   <= 1'b1;
                        state_reg <= S_W_MUL;
                    end
                    else
                        state_reg <= S_OUT;
                end
                S_X_MUL:  state_reg <= S_X_SET;
                S_X_SET:  state_reg <= S_E_XL;
                S_E_XL:   state_reg <= S_E_FL;
                S_E_FL:   state_reg <= S_E_INIT;
                S_E_INIT: state_reg <= S_E_TY;
                S_E_TY:   state_reg <= S_E_PR;
                S_E_PR:   state_reg <= S_E_Q;
                S_E_Q:    state_reg <= S_E_TERM;
                S_E_TERM: state_reg <= status.k_last ? S_E_DONE : S_E_TY;
                S_E_DONE:
                begin
                    if (second_reg)
                        state_reg <= S_DIV_INIT;
                    else
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_E_XL;
                    end
                end
                S_W_MUL:  state_reg <= S_W_SET;
                S_W_SET:  state_reg <= S_L_NORM;
                S_L_NORM:
                    if (status.m_norm)
                        state_reg <= S_L_SQ;
                S_L_SQ:   state_reg <= S_L_STEP;
                S_L_STEP: state_reg <= status.cnt_last ? S_L_DONE : S_L_SQ;
                S_L_DONE:
                begin
                    if (second_reg)
                        state_reg <= S_DIV_INIT;
                    else
                    begin
                        second_reg <= 1'b1;
                        state_reg  <= S_L_NORM;
                    end
                end
                S_DIV_INIT: state_reg <= S_DIV_SAT;
                S_DIV_SAT:  state_reg <= S_DIV_STEP;
                S_DIV_STEP:
                    if (status.div_last)
                        state_reg <= S_WRITE;
                S_WRITE:    state_reg <= S_OUT;
                S_OUT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        state_reg     <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

/* hdl/stick_expo_shaper_core.sv */
// ---------------------------------------------------------------------------
// stick_expo_shaper_core: stick command to setpoint shaper
// Top level joining the sequencer and the datapath to the request channels.
// ---------------------------------------------------------------------------
// Usage:
//   cmd carries one request (operation, stick_value); sp returns one request
//   holding all four setpoints after each command. Config registers are
//   written through cfg_we / cfg_index / cfg_data while the block is idle.
// Paths, from the accepting edge to sp.valid:
//   clear, link loss, yaw and thrust dead band, linear thrust: direct write.
//   roll, pitch, yaw curve: two exp series of 12 terms on the shared
//   multiplier, plus a 15-step divide.
//   thrust log curve: two 30-bit log2 squaring loops, each after a
//   normalize shift, plus the divide.
// Throughput: one command at a time; cmd.ready is high only while idle.
// Reset clears the setpoint holds, not sp, and loads the default exponents.
// Stall: a result held in the output register does not block a new command;
// a second result waits in the sequencer until the first is taken.
// ---------------------------------------------------------------------------
`default_nettype none

module stick_expo_shaper_core (
    input  wire          clk,
    input  wire          rst_n,
    ses_cmd_if.sink      cmd,
    ses_sp_if.source     sp,
    input  wire          cfg_we,
    input  wire  [2:0]   cfg_index,
    input  wire  [14:0]  cfg_data
);
    import ses_pkg::*;

    cmd_t    dp_cmd;
    status_t dp_status;

    ses_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (cmd.valid),
        .in_ready  (cmd.ready),
        .out_valid (sp.valid),
        .out_ready (sp.ready),
        .status    (dp_status),
        .cmd       (dp_cmd)
    );

    ses_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (dp_cmd),
        .status          (dp_status),
        .operation       (cmd.operation),
        .stick_value     (cmd.stick_value),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .roll_setpoint   (sp.roll_setpoint),
        .pitch_setpoint  (sp.pitch_setpoint),
        .yaw_setpoint    (sp.yaw_setpoint),
        .thrust_setpoint (sp.thrust_setpoint)
    );

endmodule

`default_nettype wire
